### rtl/swpvu_pkg.sv
// swpvu_pkg: shared constants and register codes for the particle velocity update core.
// No dependencies.
`default_nettype none

package swpvu_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned RAND_BITS_DEF  = 16;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ITER_BITS = 16;
  localparam int unsigned TV_SHIFT  = 17;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned LIM_BITS  = 31;

  localparam int unsigned IW_BASE_Q = 58982;
  localparam int unsigned C_HIGH_Q  = 163840;
  localparam int unsigned C_LOW_Q   = 32768;

  localparam logic [31:0]          IW_RST   = 32'd47829;
  localparam logic [31:0]          AC_RST   = 32'd98054;
  localparam logic [LIM_BITS-1:0]  VMAX_RST = 31'd262144;
  localparam logic [LIM_BITS-1:0]  XMAX_RST = 31'd6553600;
  localparam logic [ITER_BITS-1:0] MAXI_RST = 16'd1000;

  typedef enum logic [2:0] {
    REG_INERTIA_WEIGHT = 3'd0,
    REG_ACCEL_COEF     = 3'd1,
    REG_VMAX           = 3'd2,
    REG_XMAX           = 3'd3,
    REG_MAX_ITERATIONS = 3'd4,
    REG_INERTIA_MODE   = 3'd5,
    REG_ACCEL_MODE     = 3'd6,
    REG_USE_GLOBAL     = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

### rtl/swarm_particle_velocity_update_core.sv
// Pipeline: 33 divider stages, then 6 arithmetic stages, from input accept to output word.
// Throughput: one word per cycle; the pipeline holds while an output word is stalled.
// Time-varying terms come from a one-bit-per-stage divider of the iteration by max_iterations.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// Depends on swpvu_pkg.
`default_nettype none

module swarm_particle_velocity_update_core #(
  parameter int unsigned VALUE_BITS = swpvu_pkg::VALUE_BITS_DEF,
  parameter int unsigned RAND_BITS  = swpvu_pkg::RAND_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [swpvu_pkg::ADDR_BITS-1:0]      paddr,
  input  wire  [swpvu_pkg::DATA_BITS-1:0]      pwdata,
  output logic [swpvu_pkg::DATA_BITS-1:0]      prdata,
  output logic                                 pready,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [swpvu_pkg::ITER_BITS-1:0]      iteration_i,
  input  wire  signed [VALUE_BITS-1:0]         position_i,
  input  wire  signed [VALUE_BITS-1:0]         velocity_i,
  input  wire  signed [VALUE_BITS-1:0]         personal_best_i,
  input  wire  signed [VALUE_BITS-1:0]         local_best_i,
  input  wire  signed [VALUE_BITS-1:0]         global_best_i,
  input  wire  [RAND_BITS-1:0]                 rand_personal_i,
  input  wire  [RAND_BITS-1:0]                 rand_social_i,
  input  wire                                  last_in_particle_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [VALUE_BITS-1:0]         new_position_o,
  output logic signed [VALUE_BITS-1:0]         new_velocity_o,
  output logic                                 last_of_particle_o
);
  import swpvu_pkg::*;

  localparam int unsigned W    = VALUE_BITS;
  localparam int unsigned R    = RAND_BITS;
  localparam int unsigned KW   = (W > 32) ? W : 32;
  localparam int unsigned DW   = ITER_BITS;
  localparam int unsigned NB   = ITER_BITS + TV_SHIFT;
  localparam int unsigned AW   = ((W > NB + 2) ? W : NB + 2) + 1;
  localparam int unsigned PW   = KW + R + 1;
  localparam int unsigned TW   = KW + W + 2;
  localparam int unsigned VW   = KW + W;
  localparam int unsigned SUMW = TW - FRAC_BITS + 2;
  localparam int unsigned CW   = KW + 2;

  localparam logic signed [AW-1:0]   AHI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0]   ALO = ~AHI;
  localparam logic signed [SUMW-1:0] SHI = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SLO = ~SHI;

  // configuration registers
  logic [31:0]          iw_q, ac_q;
  logic [LIM_BITS-1:0]  vmax_q, xmax_q;
  logic [ITER_BITS-1:0] maxi_q;
  logic                 imode_q, amode_q, ugb_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q    <= IW_RST;
      ac_q    <= AC_RST;
      vmax_q  <= VMAX_RST;
      xmax_q  <= XMAX_RST;
      maxi_q  <= MAXI_RST;
      imode_q <= 1'b0;
      amode_q <= 1'b0;
      ugb_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INERTIA_WEIGHT: iw_q    <= pwdata;
        REG_ACCEL_COEF:     ac_q    <= pwdata;
        REG_VMAX:           vmax_q  <= pwdata[LIM_BITS-1:0];
        REG_XMAX:           xmax_q  <= pwdata[LIM_BITS-1:0];
        REG_MAX_ITERATIONS: maxi_q  <= pwdata[ITER_BITS-1:0];
        REG_INERTIA_MODE:   imode_q <= pwdata[0];
        REG_ACCEL_MODE:     amode_q <= pwdata[0];
        REG_USE_GLOBAL:     ugb_q   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_INERTIA_WEIGHT: prdata = iw_q;
      REG_ACCEL_COEF:     prdata = ac_q;
      REG_VMAX:           prdata = {1'b0, vmax_q};
      REG_XMAX:           prdata = {1'b0, xmax_q};
      REG_MAX_ITERATIONS: prdata = {{(DATA_BITS-ITER_BITS){1'b0}}, maxi_q};
      REG_INERTIA_MODE:   prdata = {{(DATA_BITS-1){1'b0}}, imode_q};
      REG_ACCEL_MODE:     prdata = {{(DATA_BITS-1){1'b0}}, amode_q};
      REG_USE_GLOBAL:     prdata = {{(DATA_BITS-1){1'b0}}, ugb_q};
    endcase
  end

  // pipeline advance
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [DW-1:0] m_div;
  assign m_div = (maxi_q == '0) ? DW'(1) : maxi_q;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] v;
    logic signed [W-1:0] pb;
    logic signed [W-1:0] att;
    logic [R-1:0]        r1;
    logic [R-1:0]        r2;
    logic                last;
  } pay_t;

  // divider stages: iteration * 2^17 / M, one quotient bit per stage
  pay_t          dpay_q [NB];
  logic [DW-1:0] drem_q [NB];
  logic [NB-1:0] dquo_q [NB];
  logic [NB-1:0] dvld_q;

  pay_t in_pay;
  assign in_pay = '{x: position_i, v: velocity_i, pb: personal_best_i,
                    att: (ugb_q ? global_best_i : local_best_i),
                    r1: rand_personal_i, r2: rand_social_i, last: last_in_particle_i};

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [DW-1:0] rem_p, rem_d;
    logic [NB-1:0] quo_p, quo_d;
    logic [DW:0]   trial;
    logic          ge;
    pay_t          pay_p;
    logic          vld_p;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign quo_p = {iteration_i, {TV_SHIFT{1'b0}}};
      assign pay_p = in_pay;
      assign vld_p = in_valid_i;
    end else begin : g_rest
      assign rem_p = drem_q[k-1];
      assign quo_p = dquo_q[k-1];
      assign pay_p = dpay_q[k-1];
      assign vld_p = dvld_q[k-1];
    end

    always_comb begin
      trial = {rem_p, quo_p[NB-1]};
      ge    = trial >= {1'b0, m_div};
      rem_d = ge ? DW'(trial - {1'b0, m_div}) : trial[DW-1:0];
      quo_d = {quo_p[NB-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[k] <= 1'b0;
      end else if (adv) begin
        dvld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        drem_q[k] <= rem_d;
        dquo_q[k] <= quo_d;
        dpay_q[k] <= pay_p;
      end
    end
  end

  // stage A: coefficients and differences
  logic [NB-1:0]        q;
  logic                 rnz;
  logic [NB-1:0]        ceil15;
  logic signed [AW-1:0] w_tv, c1_tv, c2_tv;
  logic signed [KW-1:0] w_d, c1_d, c2_d, w_tv_s, c1_tv_s, c2_tv_s;
  pay_t                 pa;

  assign q   = dquo_q[NB-1];
  assign rnz = |drem_q[NB-1];
  assign pa  = dpay_q[NB-1];

  always_comb begin
    ceil15  = {2'b00, q[NB-1:2]} + NB'((q[1:0] != 2'b00) || rnz);
    w_tv    = AW'(IW_BASE_Q) - $signed({{(AW-NB){1'b0}}, ceil15});
    c1_tv   = AW'(C_HIGH_Q) - $signed({{(AW-NB){1'b0}}, q});
    c2_tv   = AW'(C_LOW_Q) + $signed({{(AW-NB){1'b0}}, q});
    w_tv_s  = (w_tv > AHI) ? KW'(AHI) : (w_tv < ALO) ? KW'(ALO) : KW'(w_tv);
    c1_tv_s = (c1_tv > AHI) ? KW'(AHI) : (c1_tv < ALO) ? KW'(ALO) : KW'(c1_tv);
    c2_tv_s = (c2_tv > AHI) ? KW'(AHI) : (c2_tv < ALO) ? KW'(ALO) : KW'(c2_tv);
    w_d     = imode_q ? w_tv_s : KW'($signed(iw_q));
    c1_d    = amode_q ? c1_tv_s : KW'($signed(ac_q));
    c2_d    = amode_q ? c2_tv_s : KW'($signed(ac_q));
  end

  logic                 a_vld_q;
  logic signed [KW-1:0] a_w_q, a_c1_q, a_c2_q;
  logic signed [W:0]    a_d1_q, a_d2_q;
  logic signed [W-1:0]  a_x_q, a_v_q;
  logic [R-1:0]         a_r1_q, a_r2_q;
  logic                 a_last_q;

  // stage B: first products
  logic                 b_vld_q;
  logic signed [PW-1:0] b_p1_q, b_p2_q;
  logic signed [VW-1:0] b_pv_q;
  logic signed [W:0]    b_d1_q, b_d2_q;
  logic signed [W-1:0]  b_x_q;
  logic                 b_last_q;

  // stage C: attraction products
  logic                 c_vld_q;
  logic signed [TW-1:0] c_t1_q, c_t2_q;
  logic signed [VW-1:0] c_pv_q;
  logic signed [W-1:0]  c_x_q;
  logic                 c_last_q;
  logic signed [KW:0]   phi1, phi2;

  assign phi1 = b_p1_q[PW-1:R];
  assign phi2 = b_p2_q[PW-1:R];

  // stage D: sum
  logic                   d_vld_q;
  logic signed [SUMW-1:0] d_sum_q, sum_d;
  logic signed [W-1:0]    d_x_q;
  logic                   d_last_q;

  assign sum_d = SUMW'($signed(c_pv_q[VW-1:FRAC_BITS]))
               + SUMW'($signed(c_t1_q[TW-1:FRAC_BITS]))
               + SUMW'($signed(c_t2_q[TW-1:FRAC_BITS]));

  // stage E: saturate and clamp velocity
  logic                 e_vld_q;
  logic signed [CW-1:0] e_v_q, vsat, vlim, v_d;
  logic signed [W-1:0]  e_x_q;
  logic                 e_last_q;

  always_comb begin
    vsat = (d_sum_q > SHI) ? CW'(SHI) : (d_sum_q < SLO) ? CW'(SLO) : CW'(d_sum_q);
    vlim = $signed({{(CW-LIM_BITS){1'b0}}, vmax_q});
    v_d  = (vsat > vlim) ? vlim : (vsat < -vlim) ? -vlim : vsat;
  end

  // stage F: position update and clamp
  logic signed [CW:0] xs, xlim;
  logic signed [W-1:0] np_d, nv_d;

  always_comb begin
    xs   = (CW+1)'(e_x_q) + (CW+1)'(e_v_q);
    xlim = $signed({{(CW+1-LIM_BITS){1'b0}}, xmax_q});
    np_d = W'(xs);
    nv_d = W'(e_v_q);
    if (xs > xlim) begin
      np_d = W'(xlim);
      nv_d = '0;
    end else if (xs < -xlim) begin
      np_d = W'(-xlim);
      nv_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      a_vld_q     <= dvld_q[NB-1];
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      d_vld_q     <= c_vld_q;
      e_vld_q     <= d_vld_q;
      out_valid_o <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_w_q    <= w_d;
      a_c1_q   <= c1_d;
      a_c2_q   <= c2_d;
      a_d1_q   <= (W+1)'(pa.pb) - (W+1)'(pa.x);
      a_d2_q   <= (W+1)'(pa.att) - (W+1)'(pa.x);
      a_x_q    <= pa.x;
      a_v_q    <= pa.v;
      a_r1_q   <= pa.r1;
      a_r2_q   <= pa.r2;
      a_last_q <= pa.last;

      b_p1_q   <= PW'(a_c1_q) * $signed({1'b0, a_r1_q});
      b_p2_q   <= PW'(a_c2_q) * $signed({1'b0, a_r2_q});
      b_pv_q   <= VW'(a_w_q) * VW'(a_v_q);
      b_d1_q   <= a_d1_q;
      b_d2_q   <= a_d2_q;
      b_x_q    <= a_x_q;
      b_last_q <= a_last_q;

      c_t1_q   <= TW'(phi1) * TW'(b_d1_q);
      c_t2_q   <= TW'(phi2) * TW'(b_d2_q);
      c_pv_q   <= b_pv_q;
      c_x_q    <= b_x_q;
      c_last_q <= b_last_q;

      d_sum_q  <= sum_d;
      d_x_q    <= c_x_q;
      d_last_q <= c_last_q;

      e_v_q    <= v_d;
      e_x_q    <= d_x_q;
      e_last_q <= d_last_q;

      new_position_o     <= np_d;
      new_velocity_o     <= nv_d;
      last_of_particle_o <= e_last_q;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  a_hold_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(dvld_q) && $stable({a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q})))
    else $error("pipeline valid bits moved during hold");

  a_vel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q |-> ((e_v_q <= vlim) && (e_v_q >= -vlim)))
    else $error("velocity beyond vmax after clamp");
`endif

endmodule

`default_nettype wire

### sim/swarm_particle_velocity_update_core_checker.sv
// Checker for the particle velocity update core: watches the register port and both
// word channels, predicts each updated position and velocity, compares in order.
// Depends on swpvu_pkg.
`timescale 1ns / 1ps

module swarm_particle_velocity_update_core_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [15:0]         iteration_i,
  input  logic signed [31:0]  position_i,
  input  logic signed [31:0]  velocity_i,
  input  logic signed [31:0]  personal_best_i,
  input  logic signed [31:0]  local_best_i,
  input  logic signed [31:0]  global_best_i,
  input  logic [15:0]         rand_personal_i,
  input  logic [15:0]         rand_social_i,
  input  logic                last_in_particle_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic signed [31:0]  new_position_o,
  input  logic signed [31:0]  new_velocity_o,
  input  logic                last_of_particle_o,
  output int                  fail_count,
  output int                  words_pending
);
  import swpvu_pkg::*;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               last;
  } move_t;

  logic signed [31:0] iw_q;
  logic signed [31:0] ac_q;
  logic [30:0]        vmax_q;
  logic [30:0]        xmax_q;
  logic [15:0]        maxi_q;
  logic               imode_q;
  logic               amode_q;
  logic               gbest_q;
  move_t              moves_q[$];

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic move_t predict_move();
    longint m, it, x, w, c1, c2, t, phi1, phi2, att, nv, lim;
    move_t r;
    m = (maxi_q == 16'd0) ? 1 : longint'(maxi_q);
    it = longint'(iteration_i);
    x = longint'(position_i);
    if (imode_q) w = sat32(26214 + floor_quot(32768 * (m - it), m));
    else w = longint'(iw_q);
    if (amode_q) begin
      t = floor_quot(131072 * it, m);
      c1 = sat32(163840 - t);
      c2 = sat32(32768 + t);
    end else begin
      c1 = longint'(ac_q);
      c2 = c1;
    end
    phi1 = (c1 * longint'(rand_personal_i)) >>> 16;
    phi2 = (c2 * longint'(rand_social_i)) >>> 16;
    att = gbest_q ? longint'(global_best_i) : longint'(local_best_i);
    nv = sat32(((w * longint'(velocity_i)) >>> 16)
             + ((phi1 * (longint'(personal_best_i) - x)) >>> 16)
             + ((phi2 * (att - x)) >>> 16));
    lim = longint'(vmax_q);
    if (nv > lim) nv = lim;
    if (nv < -lim) nv = -lim;
    x = x + nv;
    lim = longint'(xmax_q);
    if (x > lim) begin
      x = lim;
      nv = 0;
    end
    if (x < -lim) begin
      x = -lim;
      nv = 0;
    end
    r.pos = x[31:0];
    r.vel = nv[31:0];
    r.last = last_in_particle_i;
    return r;
  endfunction

  assign words_pending = moves_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= IW_RST;
      ac_q <= AC_RST;
      vmax_q <= VMAX_RST;
      xmax_q <= XMAX_RST;
      maxi_q <= MAXI_RST;
      imode_q <= 1'b0;
      amode_q <= 1'b0;
      gbest_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_INERTIA_WEIGHT: iw_q <= pwdata;
        REG_ACCEL_COEF:     ac_q <= pwdata;
        REG_VMAX:           vmax_q <= pwdata[30:0];
        REG_XMAX:           xmax_q <= pwdata[30:0];
        REG_MAX_ITERATIONS: maxi_q <= pwdata[15:0];
        REG_INERTIA_MODE:   imode_q <= pwdata[0];
        REG_ACCEL_MODE:     amode_q <= pwdata[0];
        REG_USE_GLOBAL:     gbest_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  initial fail_count = 0;

  always @(posedge clk_i) begin
    move_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) moves_q.push_back(predict_move());
      if (out_valid_o && !out_stall_i) begin
        if (moves_q.size() == 0) begin
          $error("unexpected output word: position %0d velocity %0d",
                 new_position_o, new_velocity_o);
          fail_count++;
        end else begin
          exp_w = moves_q.pop_front();
          if (new_position_o !== exp_w.pos) begin
            $error("new_position: expected %0d, got %0d", exp_w.pos, new_position_o);
            fail_count++;
          end
          if (new_velocity_o !== exp_w.vel) begin
            $error("new_velocity: expected %0d, got %0d", exp_w.vel, new_velocity_o);
            fail_count++;
          end
          if (last_of_particle_o !== exp_w.last) begin
            $error("last_of_particle: expected %0b, got %0b", exp_w.last,
                   last_of_particle_o);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### sim/swarm_particle_velocity_update_core_test.sv
// Testbench top for the particle velocity update core: clock, reset, register setup,
// directed and random words under several idle and stall patterns, verdict.
// Depends on swpvu_pkg, the core and its checker.
`timescale 1ns / 1ps

module swarm_particle_velocity_update_core_test;
  import swpvu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        iteration = '0;
  logic signed [31:0] position = '0;
  logic signed [31:0] velocity = '0;
  logic signed [31:0] personal_best = '0;
  logic signed [31:0] local_best = '0;
  logic signed [31:0] global_best = '0;
  logic [15:0]        rand_personal = '0;
  logic [15:0]        rand_social = '0;
  logic               last_in = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] new_position;
  logic signed [31:0] new_velocity;
  logic               last_out;
  int                 fail_count;
  int                 words_pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_cycles = 0;
  int                 cycle_count = 0;

  swarm_particle_velocity_update_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .iteration_i(iteration), .position_i(position), .velocity_i(velocity),
    .personal_best_i(personal_best), .local_best_i(local_best),
    .global_best_i(global_best), .rand_personal_i(rand_personal),
    .rand_social_i(rand_social), .last_in_particle_i(last_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_position_o(new_position), .new_velocity_o(new_velocity),
    .last_of_particle_o(last_out)
  );

  swarm_particle_velocity_update_core_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .iteration_i(iteration), .position_i(position), .velocity_i(velocity),
    .personal_best_i(personal_best), .local_best_i(local_best),
    .global_best_i(global_best), .rand_personal_i(rand_personal),
    .rand_social_i(rand_social), .last_in_particle_i(last_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_position_o(new_position), .new_velocity_o(new_velocity),
    .last_of_particle_o(last_out),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(logic [15:0] it, logic [31:0] x, logic [31:0] v,
                           logic [31:0] pb, logic [31:0] lb, logic [31:0] gb,
                           logic [15:0] r1, logic [15:0] r2, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    iteration <= it;
    position <= x;
    velocity <= v;
    personal_best <= pb;
    local_best <= lb;
    global_best <= gb;
    rand_personal <= r1;
    rand_social <= r2;
    last_in <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_q(logic [31:0] span);
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return 32'h1;
        endcase
      end
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic logic [15:0] pick_iter(logic [15:0] horizon);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return horizon;
      default: return 16'($urandom_range(0, horizon));
    endcase
  endfunction

  initial begin
    logic [15:0] horizon;
    logic [31:0] span;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(16'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h7fffffff, 16'hffff, 16'hffff, 1'b1);
    send_word(16'hffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 16'hffff, 16'hffff, 1'b0);
    send_word(16'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0);
    send_word(16'd1000, 32'd6553600, 32'd262144, 32'd7000000, 32'd7000000,
              32'd7000000, 16'h8000, 16'h8000, 1'b1);
    send_word(16'd500, -32'sd6553600, -32'sd262144, -32'sd9000000, 32'd9000000,
              32'd0, 16'h0001, 16'hfffe, 1'b0);
    for (int i = 0; i < 15; i++)
      send_word(16'($urandom), pick_q(32'h00400000), pick_q(32'h00040000),
                pick_q(32'h00400000), pick_q(32'h00400000), pick_q(32'h00400000),
                16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    settle();

    for (int p = 0; p < 8; p++) begin
      horizon = (p == 2) ? 16'd0 : (p == 3) ? 16'd1 : (p == 4) ? 16'hffff
              : 16'($urandom_range(1, 3000));
      write_reg(REG_INERTIA_WEIGHT, (p == 1) ? 32'h7fffffff : (p == 2) ? 32'h80000000
                                    : $urandom_range(0, 80000));
      write_reg(REG_ACCEL_COEF, (p == 3) ? 32'h7fffffff : (p == 4) ? 32'h80000000
                                : (p == 7) ? $urandom : $urandom_range(0, 200000));
      write_reg(REG_VMAX, (p == 5) ? 32'h0 : (p == 6) ? 32'h7fffffff
                          : $urandom_range(1, 32'h00400000));
      write_reg(REG_XMAX, (p == 5) ? 32'h0 : (p == 7) ? 32'h7fffffff
                          : $urandom_range(32'h00010000, 32'h04000000));
      write_reg(REG_MAX_ITERATIONS, {16'h0, horizon});
      write_reg(REG_INERTIA_MODE, {31'b0, p[0]});
      write_reg(REG_ACCEL_MODE, {31'b0, p[1]});
      write_reg(REG_USE_GLOBAL, {31'b0, p[2]});
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      if (p == 0) hold_cycles = 300;
      span = (p == 7) ? 32'h40000000 : 32'h02000000;
      for (int i = 0; i < 75; i++)
        send_word(pick_iter(horizon), pick_q(span), pick_q(span >> 4), pick_q(span),
                  pick_q(span), pick_q(span), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)));
      settle();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
